// ===== hw/rtl/bfsp_pkg.sv =====
// shared types, constants and the sequencer microcode for the shortest path block
package bfsp_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;
    localparam int V_W  = $clog2(MAX_VERTICES);
    localparam int NV_W = $clog2(MAX_VERTICES + 1);
    localparam int E_W  = $clog2(MAX_EDGES);
    localparam int ET_W = $clog2(MAX_EDGES + 1);

    localparam logic signed [31:0] DIST_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] DIST_MIN = 32'sh8000_0000;

    // commands
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;

    // configuration register indexes
    localparam logic CFG_VCOUNT = 1'b0;
    localparam logic CFG_SOURCE = 1'b1;

    typedef struct packed {
        logic [1:0]         command;
        logic [5:0]         edge_from;
        logic [5:0]         edge_to;
        logic signed [15:0] edge_weight;
    } t_in;

    typedef struct packed {
        logic [5:0]         vertex_index;
        logic signed [31:0] distance;
        logic               reachable;
        logic               negative_cycle;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [5:0]         from_v;
        logic [5:0]         to_v;
        logic signed [15:0] weight;
    } t_edge;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] dval;
    } t_dist;

    // datapath actions
    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_INIT,
        ACT_SETUP,
        ACT_ESTART,
        ACT_EDGE_RD,
        ACT_DIST_RD,
        ACT_ADD,
        ACT_RELAX,
        ACT_PASS,
        ACT_CHECK,
        ACT_EMIT_SETUP,
        ACT_EMIT_RD,
        ACT_EMIT,
        ACT_FINISH
    } t_act;

    // jump conditions
    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_VMORE,
        C_EMORE,
        C_PASSDONE,
        C_NOEDGE,
        C_CHECK
    } t_cond;

    typedef logic [3:0] t_pc;

    localparam t_pc U_INIT   = 4'd0;
    localparam t_pc U_SETUP  = 4'd1;
    localparam t_pc U_PSTART = 4'd2;
    localparam t_pc U_ERD    = 4'd3;
    localparam t_pc U_DRD    = 4'd4;
    localparam t_pc U_ADD    = 4'd5;
    localparam t_pc U_REL    = 4'd6;
    localparam t_pc U_LEND   = 4'd7;
    localparam t_pc U_PNEXT  = 4'd8;
    localparam t_pc U_CHK    = 4'd9;
    localparam t_pc U_ESETUP = 4'd10;
    localparam t_pc U_EMRD   = 4'd11;
    localparam t_pc U_EMIT   = 4'd12;
    localparam t_pc U_FIN    = 4'd13;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_pc   target;
    } t_uword;

    // microcode rom: jump to target when cond holds, else fall through
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        case (pc)
            U_INIT:   w = '{ACT_INIT,       C_VMORE,    U_INIT};
            U_SETUP:  w = '{ACT_SETUP,      C_NOEDGE,   U_ESETUP};
            U_PSTART: w = '{ACT_ESTART,     C_PASSDONE, U_CHK};
            U_ERD:    w = '{ACT_EDGE_RD,    C_NONE,     U_ERD};
            U_DRD:    w = '{ACT_DIST_RD,    C_NONE,     U_DRD};
            U_ADD:    w = '{ACT_ADD,        C_NONE,     U_ADD};
            U_REL:    w = '{ACT_RELAX,      C_EMORE,    U_ERD};
            U_LEND:   w = '{ACT_NOP,        C_CHECK,    U_ESETUP};
            U_PNEXT:  w = '{ACT_PASS,       C_ALWAYS,   U_PSTART};
            U_CHK:    w = '{ACT_CHECK,      C_ALWAYS,   U_ERD};
            U_ESETUP: w = '{ACT_EMIT_SETUP, C_NONE,     U_ESETUP};
            U_EMRD:   w = '{ACT_EMIT_RD,    C_NONE,     U_EMRD};
            U_EMIT:   w = '{ACT_EMIT,       C_VMORE,    U_EMRD};
            U_FIN:    w = '{ACT_FINISH,     C_NONE,     U_FIN};
            default:  w = '{ACT_FINISH,     C_NONE,     U_FIN};
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/bfsp_ram.sv =====
// generic single write port ram with registered read
module bfsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/bellman_ford_shortest_path.sv =====
// top level: edge store and microcoded shortest path sequencer
//
// channel   direction  handshake                    beat
// command   in         start high, busy low         i_item (t_in)
// config    in         i_cfg_valid & o_cfg_ready    i_cfg_index, i_cfg_data
// result    out        o_res_valid, one cycle       o_result (t_result)
//
// clear and load do not raise busy, so loads can stream one beat per cycle while busy is low
// a run holds busy until its finish step; each edge relaxation is four
// microcode steps around the registered reads of the edge ram and the distance rams
// reset is synchronous, clears the sequencer and edge count and sets the config to one vertex with source 0
// during the emit phase each result follows an emit read of the distance rams, and results cannot be stalled
module bellman_ford_shortest_path
    import bfsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_in        i_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [6:0] i_cfg_data,
    output logic       o_res_valid,
    output t_result    o_result
);

    // configuration
    logic [6:0]      r_vcount;
    logic [5:0]      r_source;

    // sequencer
    logic            r_busy;
    t_pc             r_pc;
    t_pc             n_pc;
    t_uword          w_uw;
    logic            w_jump;

    // datapath registers
    logic [ET_W-1:0] r_etotal;
    logic [E_W-1:0]  r_e;
    logic [V_W-1:0]  r_vi;
    logic [NV_W-1:0] r_nv;
    logic [NV_W-1:0] r_pass;
    logic            r_check;
    logic            r_cycle;
    logic [5:0]      r_u;
    logic [5:0]      r_v;
    logic signed [15:0] r_w;
    logic signed [31:0] r_cand;
    logic            r_uok;
    logic            r_res_valid;
    t_result         r_result;

    // combinational
    logic            w_accept;
    logic            w_cfg_we;
    logic            w_ewe;
    logic [NV_W-1:0] w_nv_clamp;
    logic            w_vi_more;
    logic            w_e_more;
    logic [32:0]     w_sum;
    logic signed [31:0] w_sat;
    logic            w_improve;
    t_edge           w_edge;
    t_dist           w_da;
    t_dist           w_db;
    logic [27:0]     w_edge_rdata;
    logic [32:0]     w_da_rdata;
    logic [32:0]     w_db_rdata;
    logic            w_dre;
    logic [V_W-1:0]  w_draddr_a;
    logic [V_W-1:0]  w_draddr_b;
    logic            w_dwe;
    logic [V_W-1:0]  w_dwaddr;
    t_dist           w_dwdata;

    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;
    assign o_res_valid = r_res_valid;
    assign o_result    = r_result;

    assign w_accept = start && !r_busy;
    assign w_cfg_we = i_cfg_valid && !r_busy;
    assign w_ewe    = w_accept && (i_item.command == CMD_LOAD)
                      && (r_etotal < ET_W'(MAX_EDGES));

    // vertex count of zero acts as one, anything above the store acts as full
    always_comb begin
        if (r_vcount == 7'd0) begin
            w_nv_clamp = NV_W'(1);
        end else if (NV_W'(r_vcount) > NV_W'(MAX_VERTICES) || r_vcount > 7'(MAX_VERTICES)) begin
            w_nv_clamp = NV_W'(MAX_VERTICES);
        end else begin
            w_nv_clamp = NV_W'(r_vcount);
        end
    end

    assign w_vi_more = (NV_W'(r_vi) + NV_W'(1)) != r_nv;
    assign w_e_more  = (ET_W'(r_e) + ET_W'(1)) != r_etotal;

    // microcode fetch and branch
    assign w_uw = ucode(r_pc);

    always_comb begin
        case (w_uw.cond)
            C_NONE:     w_jump = 1'b0;
            C_ALWAYS:   w_jump = 1'b1;
            C_VMORE:    w_jump = w_vi_more;
            C_EMORE:    w_jump = w_e_more;
            C_PASSDONE: w_jump = (r_pass >= r_nv);
            C_NOEDGE:   w_jump = (r_etotal == '0);
            C_CHECK:    w_jump = r_check;
            default:    w_jump = 1'b0;
        endcase
        n_pc = w_jump ? w_uw.target : t_pc'(r_pc + 4'd1);
    end

    // edge memory
    bfsp_ram #(
        .WIDTH (28),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_ewe),
        .i_waddr (r_etotal[E_W-1:0]),
        .i_wdata ({i_item.edge_from, i_item.edge_to, i_item.edge_weight}),
        .i_re    (r_busy && (w_uw.act == ACT_EDGE_RD)),
        .i_raddr (r_e),
        .o_rdata (w_edge_rdata)
    );

    assign w_edge = t_edge'(w_edge_rdata);

    // distance reads: both endpoints of an edge, or one vertex while emitting
    always_comb begin
        w_dre      = 1'b0;
        w_draddr_a = w_edge.from_v[V_W-1:0];
        w_draddr_b = w_edge.to_v[V_W-1:0];
        if (r_busy && w_uw.act == ACT_DIST_RD) begin
            w_dre = 1'b1;
        end else if (r_busy && w_uw.act == ACT_EMIT_RD) begin
            w_dre      = 1'b1;
            w_draddr_a = r_vi;
        end
    end

    // candidate distance, saturated to 32 bits
    assign w_da  = t_dist'(w_da_rdata);
    assign w_db  = t_dist'(w_db_rdata);
    assign w_sum = {w_da.dval[31], w_da.dval} + {{17{r_w[15]}}, r_w};

    always_comb begin
        if (w_sum[32] != w_sum[31]) begin
            w_sat = w_sum[32] ? DIST_MIN : DIST_MAX;
        end else begin
            w_sat = w_sum[31:0];
        end
    end

    assign w_improve = r_uok && (!w_db.ok || (r_cand < w_db.dval));

    // distance writes: initialization sweep or an applied relaxation
    always_comb begin
        w_dwe    = 1'b0;
        w_dwaddr = r_v[V_W-1:0];
        w_dwdata = '{ok: 1'b1, dval: r_cand};
        if (r_busy && w_uw.act == ACT_INIT) begin
            w_dwe    = 1'b1;
            w_dwaddr = r_vi;
            w_dwdata = '{ok: (r_vi == r_source[V_W-1:0]), dval: '0};
        end else if (r_busy && w_uw.act == ACT_RELAX && !r_check && w_improve) begin
            w_dwe = 1'b1;
        end
    end

    // two copies so both edge endpoints are read in the same cycle
    bfsp_ram #(
        .WIDTH (33),
        .DEPTH (MAX_VERTICES)
    ) u_dist_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_dwe),
        .i_waddr (w_dwaddr),
        .i_wdata (w_dwdata),
        .i_re    (w_dre),
        .i_raddr (w_draddr_a),
        .o_rdata (w_da_rdata)
    );

    bfsp_ram #(
        .WIDTH (33),
        .DEPTH (MAX_VERTICES)
    ) u_dist_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_dwe),
        .i_waddr (w_dwaddr),
        .i_wdata (w_dwdata),
        .i_re    (w_dre),
        .i_raddr (w_draddr_b),
        .o_rdata (w_db_rdata)
    );

    // sequencer state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount    <= 7'd1;
            r_source    <= 6'd0;
            r_busy      <= 1'b0;
            r_pc        <= U_INIT;
            r_etotal    <= '0;
            r_check     <= 1'b0;
            r_cycle     <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            // result strobe for exactly the emit step
            r_res_valid <= r_busy && (w_uw.act == ACT_EMIT);

            if (w_cfg_we) begin
                case (i_cfg_index)
                    CFG_VCOUNT: r_vcount <= i_cfg_data;
                    CFG_SOURCE: r_source <= i_cfg_data[5:0];
                    default:    r_vcount <= r_vcount;
                endcase
            end

            if (w_accept) begin
                case (i_item.command)
                    CMD_CLEAR: r_etotal <= '0;
                    CMD_LOAD: begin
                        if (w_ewe) begin
                            r_etotal <= r_etotal + ET_W'(1);
                        end
                    end
                    CMD_RUN: begin
                        r_busy <= 1'b1;
                        r_pc   <= U_INIT;
                        r_vi   <= '0;
                        r_nv   <= w_nv_clamp;
                    end
                    default: r_busy <= 1'b0;
                endcase
            end

            if (r_busy) begin
                r_pc <= n_pc;
                case (w_uw.act)
                    ACT_INIT: r_vi <= r_vi + V_W'(1);
                    ACT_SETUP: begin
                        r_pass  <= NV_W'(1);
                        r_check <= 1'b0;
                        r_cycle <= 1'b0;
                        r_e     <= '0;
                    end
                    ACT_ESTART: r_e <= '0;
                    ACT_DIST_RD: begin
                        r_u <= w_edge.from_v;
                        r_v <= w_edge.to_v;
                        r_w <= w_edge.weight;
                    end
                    ACT_ADD: begin
                        r_cand <= w_sat;
                        r_uok  <= w_da.ok && (NV_W'(r_u) < r_nv) && (NV_W'(r_v) < r_nv);
                    end
                    ACT_RELAX: begin
                        if (r_check && w_improve) begin
                            r_cycle <= 1'b1;
                        end
                        r_e <= r_e + E_W'(1);
                    end
                    ACT_PASS: r_pass <= r_pass + NV_W'(1);
                    ACT_CHECK: begin
                        r_check <= 1'b1;
                        r_e     <= '0;
                    end
                    ACT_EMIT_SETUP: r_vi <= '0;
                    ACT_EMIT: begin
                        r_result.vertex_index      <= 6'(r_vi);
                        r_result.distance          <= w_da.ok ? w_da.dval : '0;
                        r_result.reachable         <= w_da.ok;
                        r_result.negative_cycle    <= r_cycle;
                        r_result.last              <= !w_vi_more;
                        r_vi                       <= r_vi + V_W'(1);
                    end
                    ACT_FINISH: r_busy <= 1'b0;
                    default: r_busy <= r_busy;
                endcase
            end
        end
    end

    // results only come out while a run holds the block
    a_res_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> r_busy)
        else $error("result strobe outside a run");

    // the last result of a run is never followed by another one
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_result.last) |=> !r_res_valid)
        else $error("result after the last vertex");

    // edge count never passes the edge memory depth
    a_etotal_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_etotal <= ET_W'(MAX_EDGES))
        else $error("edge count beyond memory depth");

    // the sequencer stays inside its program while running
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc <= U_FIN))
        else $error("microcode step out of range");

endmodule

// ===== sim/bellman_ford_shortest_path_tb.sv =====
// self-checking testbench for the shortest path block: command beats, config writes, vertex results
module bellman_ford_shortest_path_tb;
    import bfsp_pkg::*;

    localparam int         CLOCK_LIMIT  = 10_000_000;
    localparam int         RANDOM_BEATS = 50;     // per idle phase, three phases
    localparam int         DRAIN_CYCLES = 16;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    logic       busy;
    t_in        i_item      = '0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_index = CFG_VCOUNT;
    logic [6:0] i_cfg_data  = '0;
    logic       o_res_valid;
    t_result    o_result;

    bellman_ford_shortest_path DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (o_res_valid),
        .o_result    (o_result)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog: a hung sequencer or a lost result ends the run here
    int unsigned cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CLOCK_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("bellman_ford_shortest_path verification failed");
            $finish;
        end
    end

    // mirror of the block: edge list, config and the distance table of the current run
    t_edge      arc_mem [MAX_EDGES];
    int         arc_count  = 0;
    logic [6:0] vcount_reg = 7'd1;
    logic [5:0] source_reg = '0;
    longint     best_len [MAX_VERTICES];
    bit         best_ok  [MAX_VERTICES];
    t_result    vertex_reports_due [$];

    int items_sent      = 0;
    int runs_sent       = 0;
    int cycle_runs      = 0;
    int reports_checked = 0;
    int mismatch_count  = 0;
    int idle_pct        = 0;
    bit start_high      = 1'b0;

    // vertex count as the block uses it: 0 acts as 1, large values clamp
    function automatic int active_vertices();
        if (vcount_reg == 0) return 1;
        if (vcount_reg > MAX_VERTICES) return MAX_VERTICES;
        return int'(vcount_reg);
    endfunction

    // true when stored arc k would shorten the distance of its head vertex
    function automatic bit arc_improves(int k, int nv, output longint cand);
        int u;
        int v;
        u = int'(arc_mem[k].from_v);
        v = int'(arc_mem[k].to_v);
        cand = 0;
        if (u >= nv || v >= nv || !best_ok[u]) return 1'b0;
        cand = best_len[u] + longint'($signed(arc_mem[k].weight));
        if (cand > longint'(DIST_MAX)) cand = longint'(DIST_MAX);
        if (cand < longint'(DIST_MIN)) cand = longint'(DIST_MIN);
        return !best_ok[v] || cand < best_len[v];
    endfunction

    // apply one accepted command beat and queue the vertex results it causes
    function automatic void predict_command(input t_in it);
        int      nv;
        bit      cycle_seen;
        longint  cand;
        t_result r;
        case (it.command)
            CMD_CLEAR: arc_count = 0;
            CMD_LOAD: begin
                // a full edge memory drops further loads
                if (arc_count < MAX_EDGES) begin
                    arc_mem[arc_count] = '{it.edge_from, it.edge_to, it.edge_weight};
                    arc_count++;
                end
            end
            CMD_RUN: begin
                nv = active_vertices();
                // a source at or above the vertex count leaves every vertex unreachable
                for (int v = 0; v < nv; v++) begin
                    best_ok[v]  = (v == int'(source_reg));
                    best_len[v] = 0;
                end
                for (int p = 1; p < nv; p++) begin
                    for (int k = 0; k < arc_count; k++) begin
                        if (arc_improves(k, nv, cand)) begin
                            best_len[int'(arc_mem[k].to_v)] = cand;
                            best_ok[int'(arc_mem[k].to_v)]  = 1'b1;
                        end
                    end
                end
                cycle_seen = 1'b0;
                for (int k = 0; k < arc_count; k++) begin
                    if (arc_improves(k, nv, cand)) cycle_seen = 1'b1;
                end
                if (cycle_seen) cycle_runs++;
                for (int v = 0; v < nv; v++) begin
                    r.vertex_index   = 6'(v);
                    r.distance       = best_ok[v] ? best_len[v][31:0] : '0;
                    r.reachable      = best_ok[v];
                    r.negative_cycle = cycle_seen;
                    r.last           = (v == nv - 1);
                    vertex_reports_due.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_in make_item(logic [1:0] cmd, logic [5:0] src_v, logic [5:0] dst_v,
                                      logic [15:0] w);
        t_in it;
        it.command     = cmd;
        it.edge_from   = src_v;
        it.edge_to     = dst_v;
        it.edge_weight = w;
        return it;
    endfunction

    // present one command beat, at times with a random gap in front, and wait until it is taken
    task automatic send_item(input t_in it);
        int gap;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 6);
            if (start_high) start <= 1'b0;
            start_high = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        start_high  = 1'b1;
        i_item     <= it;
        do @(posedge i_clk); while (busy);
        predict_command(it);
        if (it.command != CMD_UNUSED) items_sent++;
        if (it.command == CMD_RUN) runs_sent++;
    endtask

    // command with don't-care edge fields randomized
    task automatic send_command(input logic [1:0] cmd);
        send_item(make_item(cmd, 6'($urandom), 6'($urandom), 16'($urandom)));
    endtask

    task automatic load_arc(input logic [5:0] src_v, input logic [5:0] dst_v,
                            input logic [15:0] w);
        send_item(make_item(CMD_LOAD, src_v, dst_v, w));
    endtask

    // stop sending, let every pending result arrive and the sequencer settle
    task automatic hold_off();
        if (start_high) start <= 1'b0;
        start_high = 1'b0;
        while (vertex_reports_due.size() != 0 || busy) @(posedge i_clk);
        // a trailing clear or load can still be in flight
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_config(input logic idx, input logic [6:0] value);
        hold_off();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_VCOUNT) vcount_reg = value;
        else source_reg = value[5:0];
    endtask

    // result side: every strobe must match the oldest queued vertex report
    function automatic void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_res_valid) begin
            if (vertex_reports_due.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual %p",
                         $time, o_result);
                mismatch_count++;
            end else begin
                want = vertex_reports_due.pop_front();
                reports_checked++;
                compare_field("vertex_index", 32'(want.vertex_index), 32'(o_result.vertex_index));
                compare_field("distance", want.distance, o_result.distance);
                compare_field("reachable", 32'(want.reachable), 32'(o_result.reachable));
                compare_field("negative_cycle", 32'(want.negative_cycle),
                              32'(o_result.negative_cycle));
                compare_field("last", 32'(want.last), 32'(o_result.last));
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // reset config: one vertex which is the source, no edges
    task automatic test_reset_state();
        send_command(CMD_RUN);
    endtask

    // four vertices, extreme weights, endpoints beyond the vertex count skipped
    task automatic test_basic_paths();
        write_config(CFG_VCOUNT, 7'd4);
        write_config(CFG_SOURCE, 7'd0);
        send_command(CMD_CLEAR);
        load_arc(6'd0, 6'd1, 16'sh7FFF);
        load_arc(6'd1, 6'd2, 16'sh8000);
        load_arc(6'd0, 6'd2, 16'sd5);
        load_arc(6'd2, 6'd3, 16'sd0);
        load_arc(6'd63, 6'd0, -16'sd9);
        load_arc(6'd0, 6'd63, -16'sd9);
        send_command(CMD_RUN);
    endtask

    // a reachable loop with negative total weight
    task automatic test_negative_cycle();
        send_command(CMD_CLEAR);
        load_arc(6'd0, 6'd1, 16'sd2);
        load_arc(6'd1, 6'd2, -16'sd3);
        load_arc(6'd2, 6'd1, 16'sd1);
        send_command(CMD_RUN);
    endtask

    // vertex count 0 acts as 1: no passes, but the check pass still sees a self loop
    task automatic test_single_vertex();
        write_config(CFG_VCOUNT, 7'd0);
        send_command(CMD_CLEAR);
        load_arc(6'd0, 6'd0, -16'sd1);
        send_command(CMD_RUN);
        write_config(CFG_VCOUNT, 7'd1);
        send_command(CMD_RUN);
    endtask

    // source outside the graph, including the top config data bit
    task automatic test_source_out_of_range();
        write_config(CFG_VCOUNT, 7'd5);
        write_config(CFG_SOURCE, 7'd127);
        send_command(CMD_RUN);
        write_config(CFG_SOURCE, 7'd5);
        send_command(CMD_RUN);
    endtask

    // command 3 must leave the edge list alone and raise no result
    task automatic test_unused_command();
        write_config(CFG_SOURCE, 7'd2);
        send_item(make_item(CMD_UNUSED, 6'h3F, 6'h3F, 16'hFFFF));
        send_command(CMD_RUN);
    endtask

    // largest graph in range, endpoints at both ends of their fields
    task automatic test_max_vertices();
        write_config(CFG_VCOUNT, 7'd64);
        write_config(CFG_SOURCE, 7'd0);
        send_command(CMD_CLEAR);
        load_arc(6'd0, 6'd63, 16'sh8000);
        load_arc(6'd63, 6'd62, 16'sh7FFF);
        send_command(CMD_RUN);
    endtask

    // overfill the edge memory with a clamped vertex count; loads past the end are dropped
    task automatic test_edge_memory_full();
        write_config(CFG_VCOUNT, 7'd127);
        write_config(CFG_SOURCE, 7'd63);
        send_command(CMD_CLEAR);
        repeat (MAX_EDGES + 4) load_arc(6'($urandom), 6'($urandom), 16'($urandom));
        send_command(CMD_RUN);
        write_config(CFG_VCOUNT, 7'd3);
        write_config(CFG_SOURCE, 7'd0);
        send_command(CMD_CLEAR);
    endtask

    // one graph: optional config change, optional clear, a batch of edges, then a run
    task automatic random_session();
        int nv;
        int arcs;
        int roll;
        int bias;
        roll = $urandom_range(99);
        if (roll < 12) write_config(CFG_VCOUNT, 7'($urandom_range(0, 127)));
        else if (roll < 60) write_config(CFG_VCOUNT, 7'($urandom_range(2, 10)));
        nv   = active_vertices();
        roll = $urandom_range(99);
        if (roll < 10) write_config(CFG_SOURCE, 7'($urandom_range(0, 127)));
        else if (roll < 50) write_config(CFG_SOURCE, 7'($urandom_range(0, nv - 1)));
        // keep accumulated lists short so a run stays cheap
        if (arc_count > 40 || $urandom_range(99) < 85) send_command(CMD_CLEAR);
        arcs = $urandom_range(0, (3 * nv < 24) ? 3 * nv : 24);
        bias = $urandom_range(0, 14);
        repeat (arcs) begin
            roll = $urandom_range(99);
            if (roll < 4) send_command(CMD_UNUSED);
            else if (roll < 12) load_arc(6'($urandom), 6'($urandom), 16'($urandom));
            else load_arc(6'($urandom_range(0, nv - 1)), 6'($urandom_range(0, nv - 1)),
                          16'(int'($urandom_range(0, 60)) - bias));
        end
        // now and then let the block drain completely before the run
        if ($urandom_range(99) < 15) hold_off();
        send_command(CMD_RUN);
    endtask

    task automatic test_random_graphs(input int pct);
        int goal;
        idle_pct = pct;
        goal     = items_sent + RANDOM_BEATS;
        while (items_sent < goal) random_session();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 27;
        test_reset_state();
        test_basic_paths();
        test_negative_cycle();
        test_single_vertex();
        test_source_out_of_range();
        test_unused_command();
        test_max_vertices();
        test_edge_memory_full();

        test_random_graphs(27);
        test_random_graphs(52);
        test_random_graphs(0);

        hold_off();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d command beats in %0d runs, %0d vertex results checked, %0d runs with a cycle",
                 items_sent, runs_sent, reports_checked, cycle_runs);
        $display("graphs from 1 to 64 vertices, clamped counts, off-graph sources and edges,");
        $display("full edge memory");
        if (mismatch_count == 0 && vertex_reports_due.size() == 0) begin
            $display("bellman_ford_shortest_path verification clean");
        end else begin
            $display("bellman_ford_shortest_path verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bfsp_pkg.sv
hw/rtl/bfsp_ram.sv
hw/rtl/bellman_ford_shortest_path.sv
sim/bellman_ford_shortest_path_tb.sv
